// ===== rtl/crcfr_pkg.sv =====
// Package: shared types, codes and the CRC-16 byte fold for the frame receiver.
package crcfr_pkg;

    typedef enum logic [1:0] {
        PHASE_HUNT   = 2'd0,
        PHASE_LEN_HI = 2'd1,
        PHASE_LEN_LO = 2'd2,
        PHASE_BODY   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SYNC_BYTE  = 2'd0,
        CFG_MAX_LENGTH = 2'd1
    } t_cfg_index;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
    } t_result;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] START_RESET     = 16'h0000;
    localparam logic [15:0] MAX_LEN_RESET   = 16'hFFFF;
    localparam logic [15:0] MIN_BODY_LENGTH = 16'd2;

    // Reflected CRC-16, one byte folded in, LSB first.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int bit_i = 0; bit_i < 8; bit_i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/crcfr_out_skid.sv =====
// Output register with one skid entry for the frame receiver result channel.
module crcfr_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  crcfr_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output crcfr_pkg::t_result o_data
);

    logic               r_out_valid;
    logic               r_skid_valid;
    crcfr_pkg::t_result r_out;
    crcfr_pkg::t_result r_skid;
    logic               n_out_valid;
    logic               n_skid_valid;
    logic               out_pop;

    assign out_pop = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            // upstream is held off while the skid entry is occupied
            if (out_pop) begin
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || out_pop) begin
            n_out_valid = i_valid;
        end else if (i_valid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_pop) begin
            if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry changed while stalled");

endmodule

// ===== rtl/crc16_frame_receiver.sv =====
// Top level: length-prefixed frame receiver with Modbus CRC-16 check.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -----------------------------------------
//  in        sink       i_in_valid / o_in_stall   i_rx_byte
//  out       source     o_out_valid / i_out_stall o_kind, o_data_byte, o_byte_index,
//                                                 o_frame_length
//  cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte per cycle while o_in_stall is low. A byte is parsed and CRC-folded in the
// cycle it is accepted; its result (if any) sits in the output register, or in the skid
// entry if the output is stalled, on the next cycle. The output register plus one skid
// entry decouple the sides; o_in_stall rises only while the skid entry is occupied,
// driven straight from a flop. Reset (synchronous, active low) returns to hunting and
// loads register defaults: start byte 0x00, max length 0xFFFF. Config writes always complete.
module crc16_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received bytes
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_index,
    output logic [15:0] o_frame_length,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [7:0]  r_sync_byte;
    logic [15:0] r_max_length;

    // parser state
    crcfr_pkg::t_phase r_phase;
    crcfr_pkg::t_phase n_phase;
    logic [7:0]  r_length_high;
    logic [7:0]  n_length_high;
    logic [15:0] r_body_length;
    logic [15:0] n_body_length;
    logic [15:0] r_body_count;
    logic [15:0] n_body_count;
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    logic               in_accept;
    logic               res_valid;
    crcfr_pkg::t_result res;
    crcfr_pkg::t_result out_res;
    logic               skid_full;
    logic [15:0]        header_length;
    logic [15:0]        crc_next;

    assign in_accept     = i_in_valid && !o_in_stall;
    assign header_length = {r_length_high, i_rx_byte};
    assign crc_next      = crcfr_pkg::crc16_fold(r_crc, i_rx_byte);
    assign o_cfg_ready   = 1'b1;

    // register file: unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte  <= crcfr_pkg::START_RESET[7:0];
            r_max_length <= crcfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                crcfr_pkg::CFG_SYNC_BYTE:  r_sync_byte  <= i_cfg_data[7:0];
                crcfr_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser next state and result
    always_comb begin
        n_phase       = r_phase;
        n_length_high = r_length_high;
        n_body_length = r_body_length;
        n_body_count  = r_body_count;
        n_crc         = r_crc;
        res_valid     = 1'b0;
        res           = '0;
        if (in_accept) begin
            unique case (r_phase)
                crcfr_pkg::PHASE_HUNT: begin
                    if (i_rx_byte == r_sync_byte) begin
                        n_phase = crcfr_pkg::PHASE_LEN_HI;
                    end
                end
                crcfr_pkg::PHASE_LEN_HI: begin
                    n_length_high = i_rx_byte;
                    n_phase       = crcfr_pkg::PHASE_LEN_LO;
                end
                crcfr_pkg::PHASE_LEN_LO: begin
                    n_body_length = header_length;
                    n_body_count  = '0;
                    n_crc         = crcfr_pkg::CRC_INIT;
                    if (header_length < crcfr_pkg::MIN_BODY_LENGTH ||
                        header_length > r_max_length) begin
                        n_phase          = crcfr_pkg::PHASE_HUNT;
                        res_valid        = 1'b1;
                        res.kind         = crcfr_pkg::KIND_REJECT;
                        res.frame_length = header_length;
                    end else begin
                        n_phase = crcfr_pkg::PHASE_BODY;
                    end
                end
                crcfr_pkg::PHASE_BODY: begin
                    n_crc        = crc_next;
                    n_body_count = r_body_count + 16'd1;
                    if (r_body_count < r_body_length - crcfr_pkg::MIN_BODY_LENGTH) begin
                        res_valid        = 1'b1;
                        res.kind         = crcfr_pkg::KIND_PAYLOAD;
                        res.data_byte    = i_rx_byte;
                        res.byte_index   = r_body_count;
                        res.frame_length = r_body_length;
                    end else if ({1'b0, r_body_count} + 17'd1 >= {1'b0, r_body_length}) begin
                        // last CRC byte: zero residue means a clean frame
                        n_phase          = crcfr_pkg::PHASE_HUNT;
                        res_valid        = 1'b1;
                        res.kind         = (crc_next == 16'h0000) ? crcfr_pkg::KIND_GOOD
                                                                  : crcfr_pkg::KIND_BAD;
                        res.frame_length = r_body_length;
                    end
                end
                default: n_phase = crcfr_pkg::PHASE_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= crcfr_pkg::PHASE_HUNT;
            r_length_high <= '0;
            r_body_length <= '0;
            r_body_count  <= '0;
            r_crc         <= crcfr_pkg::CRC_INIT;
        end else begin
            r_phase       <= n_phase;
            r_length_high <= n_length_high;
            r_body_length <= n_body_length;
            r_body_count  <= n_body_count;
            r_crc         <= n_crc;
        end
    end

    crcfr_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_in_stall     = skid_full;
    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_byte_index   = out_res.byte_index;
    assign o_frame_length = out_res.frame_length;

    a_body_length_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == crcfr_pkg::PHASE_BODY) |->
            (r_body_length >= crcfr_pkg::MIN_BODY_LENGTH &&
             r_body_length <= r_max_length || $past(i_cfg_valid) || i_cfg_valid ||
             r_body_length >= crcfr_pkg::MIN_BODY_LENGTH))
        else $error("body phase entered with short length");

    a_payload_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == crcfr_pkg::KIND_PAYLOAD) |->
            ({1'b0, o_byte_index} + 17'd2 < {1'b0, o_frame_length}))
        else $error("payload index past payload end");

    a_status_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != crcfr_pkg::KIND_PAYLOAD) |->
            (o_data_byte == 8'h00 && o_byte_index == 16'h0000))
        else $error("status result carries payload fields");

    a_count_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == crcfr_pkg::PHASE_BODY) |-> (r_body_count < r_body_length))
        else $error("body count ran past body length");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for crc16_frame_receiver: framed byte traffic against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import crcfr_pkg::*;

    // Indexes past the two registers; writes there must leave both registers alone.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    localparam int HOLD_CYCLES  = 400;  // long output hold-off, fills the skid
    localparam int DRAIN_CYCLES = 8;    // quiet stretch at the end of settle
    localparam int MAX_GAP      = 20;   // cap on one sender idle stretch

    // Expected-result predictor: parser state, running CRC and queued results.
    class frame_predictor;
        logic [7:0]  sync_byte;
        logic [15:0] max_length;
        t_phase      phase;
        logic [7:0]  length_hi;
        logic [15:0] body_length;
        logic [15:0] body_count;
        logic [15:0] crc;
        t_result     pending_results[$];
        int          errors;
        int          kind_count[4];

        function new();
            errors      = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
            sync_byte   = START_RESET[7:0];
            max_length  = MAX_LEN_RESET;
            phase       = PHASE_HUNT;
            length_hi   = 8'h00;
            body_length = 16'h0000;
            body_count  = 16'h0000;
            crc         = CRC_INIT;
        endfunction

        // Modbus CRC-16, reflected, one byte at a time.
        static function logic [15:0] fold(logic [15:0] crc_in, logic [7:0] b);
            logic [15:0] c;
            c = crc_in ^ {8'h00, b};
            repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
            return c;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_SYNC_BYTE:  sync_byte  = value[7:0];
                CFG_MAX_LENGTH: max_length = value;
                default: ;
            endcase
        endfunction

        // One accepted byte: advance the parser, queue what it produces.
        function void take_byte(logic [7:0] b);
            t_result     r;
            logic [15:0] pos;
            r = '0;
            case (phase)
                PHASE_HUNT: begin
                    if (b == sync_byte) phase = PHASE_LEN_HI;
                end
                PHASE_LEN_HI: begin
                    length_hi = b;
                    phase     = PHASE_LEN_LO;
                end
                PHASE_LEN_LO: begin
                    body_length = {length_hi, b};
                    body_count  = 16'h0000;
                    crc         = CRC_INIT;
                    if (body_length < MIN_BODY_LENGTH || body_length > max_length) begin
                        phase          = PHASE_HUNT;
                        r.kind         = KIND_REJECT;
                        r.frame_length = body_length;
                        pending_results.push_back(r);
                    end else begin
                        phase = PHASE_BODY;
                    end
                end
                default: begin
                    pos            = body_count;
                    crc            = fold(crc, b);
                    body_count     = body_count + 16'd1;
                    r.frame_length = body_length;
                    if (pos < body_length - 16'd2) begin
                        r.kind       = KIND_PAYLOAD;
                        r.data_byte  = b;
                        r.byte_index = pos;
                        pending_results.push_back(r);
                    end else if ({1'b0, pos} + 17'd1 >= {1'b0, body_length}) begin
                        // last CRC byte: zero residue means the frame is intact
                        phase  = PHASE_HUNT;
                        r.kind = (crc == 16'h0000) ? KIND_GOOD : KIND_BAD;
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", field, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d length 0x%0h",
                                          got.kind, got.frame_length));
                return;
            end
            want = pending_results.pop_front();
            kind_count[want.kind]++;
            compare_field("kind", got.kind, want.kind);
            compare_field("data_byte", got.data_byte, want.data_byte);
            compare_field("byte_index", got.byte_index, want.byte_index);
            compare_field("frame_length", got.frame_length, want.frame_length);
        endtask
    endclass

    // Block-side signals; the ones driven from here are known from time zero.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  rx_byte    = 8'h00;
    logic        out_stall  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [1:0]  cfg_index  = 2'd0;
    logic [15:0] cfg_data   = 16'h0000;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  out_kind;
    logic [7:0]  out_data;
    logic [15:0] out_index;
    logic [15:0] out_length;
    logic        cfg_ready;

    // Idle profile knobs and the one-shot output hold.
    int          in_idle_pct  = 0;
    int          out_idle_pct = 0;
    logic        hold_go      = 1'b0;
    logic        hold_out     = 1'b0;
    int          bytes_sent   = 0;
    logic [7:0]  burst[$];

    frame_predictor rx_pred = new();

    crc16_frame_receiver dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (out_kind),
        .o_data_byte    (out_data),
        .o_byte_index   (out_index),
        .o_frame_length (out_length),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Output side: values sampled here are the pre-edge ones, so a result is
    // taken exactly when valid was high and our stall was low at this edge.
    always @(posedge clk) begin
        t_result got;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            got.kind         = t_kind'(out_kind);
            got.data_byte    = out_data;
            got.byte_index   = out_index;
            got.frame_length = out_length;
            rx_pred.check_result(got);
        end
        out_stall <= hold_out || ($urandom_range(99) < out_idle_pct);
    end

    // Long output hold-off, counted here while the sender keeps offering bytes.
    initial begin
        wait (hold_go);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    // One request on the byte channel; the predictor sees it at the accepting edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        rx_pred.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[i]) send_byte(burst[i]);
        burst.delete();
    endtask

    // Queue a frame: start byte, big-endian length, payload, CRC low then high.
    // A length the block must refuse gets only its header.
    function automatic void add_frame(logic [15:0] body_len, bit corrupt);
        logic [15:0] c;
        int          first;
        int          at;
        c = CRC_INIT;
        burst.push_back(rx_pred.sync_byte);
        burst.push_back(body_len[15:8]);
        burst.push_back(body_len[7:0]);
        if (body_len < MIN_BODY_LENGTH || body_len > rx_pred.max_length) return;
        first = burst.size();
        for (int i = 2; i < body_len; i++) begin
            burst.push_back(8'($urandom));
            c = frame_predictor::fold(c, burst[burst.size() - 1]);
        end
        burst.push_back(c[7:0]);
        burst.push_back(c[15:8]);
        if (corrupt) begin
            // single bit flip anywhere in the body, CRC bytes included
            at = first + $urandom_range(body_len - 1);
            burst[at] = burst[at] ^ (8'h01 << $urandom_range(7));
        end
    endfunction

    // Stop offering, let every expected result come out, then wait out DRAIN_CYCLES.
    task automatic settle();
        in_valid <= 1'b0;
        while (rx_pred.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        rx_pred.write_reg(idx, value);
    endtask

    // Registers change only with the block idle. Upper data bits on the start
    // byte write are junk on purpose; a spare index write goes along too.
    task automatic set_config(input logic [7:0] sb, input logic [15:0] max_len);
        settle();
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SYNC_BYTE, {8'($urandom), sb});
        write_reg(CFG_MAX_LENGTH, max_len);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus CRC errors, lengths
    // at and past the limit, cut-off frames and line noise.
    task automatic random_traffic(input int n_bytes);
        int          counted;
        int          pick;
        int          short_len;
        int          cut;
        logic [15:0] maxl;
        logic [15:0] rej;
        counted = 0;
        while (counted < n_bytes) begin
            maxl      = rx_pred.max_length;
            short_len = $urandom_range(16, 2);
            if (short_len > maxl) short_len = maxl;
            pick = $urandom_range(99);
            if (pick < 62) begin
                add_frame(16'(short_len), 1'b0);
            end else if (pick < 72) begin
                add_frame(16'(short_len), 1'b1);
            end else if (pick < 78) begin
                // body exactly at the configured limit when that limit is 400 or less
                add_frame((maxl <= 16'd400) ? maxl : 16'(short_len), 1'b0);
            end else if (pick < 86) begin
                case ($urandom_range(2))
                    0: rej = 16'($urandom_range(1));
                    1: rej = (maxl == 16'hFFFF) ? 16'd1 : maxl + 16'd1;
                    default: rej = (maxl == 16'hFFFF) ? 16'd0
                                                      : 16'($urandom_range(65535, maxl + 1));
                endcase
                add_frame(rej, 1'b0);
            end else if (pick < 93) begin
                // truncated frame: the next frame's bytes land in what is left of it
                add_frame(16'(short_len), 1'b0);
                cut = $urandom_range(burst.size() - 1, 1);
                repeat (cut) void'(burst.pop_back());
            end else begin
                // noise, mostly ignored while hunting so it does not count
                repeat ($urandom_range(4, 1)) burst.push_back(8'($urandom));
                counted -= burst.size();
            end
            counted += burst.size();
            send_burst();
        end
    endtask

    initial begin
        // synchronous reset, held low from time zero
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers (start 0x00, limit 0xFFFF): a stray byte
        // while hunting, an empty-payload frame, one payload byte, lengths 1 and 0.
        burst.push_back(8'h55);
        add_frame(16'd2, 1'b0);
        add_frame(16'd3, 1'b0);
        add_frame(16'd1, 1'b0);
        add_frame(16'd0, 1'b0);
        send_burst();

        // Directed, start 0xFF and smallest limit: largest header refused,
        // empty frame with a damaged CRC.
        set_config(8'hFF, MIN_BODY_LENGTH);
        add_frame(16'hFFFF, 1'b0);
        add_frame(16'd2, 1'b1);
        send_burst();

        // Sender nearly always ready, receiver mostly stalling.
        in_idle_pct  = 6;
        out_idle_pct = 80;
        set_config(8'h7E, 16'($urandom_range(24, 8)));
        random_traffic(650);

        // Reversed: sparse input, eager output.
        in_idle_pct  = 80;
        out_idle_pct = 6;
        set_config(8'($urandom), 16'($urandom_range(300, 20)));
        random_traffic(650);

        // Full rate both sides, widest limit; the output hold kicks in here so
        // the block backs up and stalls the input.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_config(8'($urandom), 16'hFFFF);
        hold_go = 1'b1;
        random_traffic(700);
        settle();

        $display("run: %0d bytes in, %0d payload, %0d good, %0d crc-bad, %0d refused results",
                 bytes_sent, rx_pred.kind_count[KIND_PAYLOAD], rx_pred.kind_count[KIND_GOOD],
                 rx_pred.kind_count[KIND_BAD], rx_pred.kind_count[KIND_REJECT]);
        $display("run: three idle profiles and a %0d-cycle output hold", HOLD_CYCLES);
        if (rx_pred.errors == 0 && rx_pred.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== crc16_frame_receiver.f =====
rtl/crcfr_pkg.sv
rtl/crcfr_out_skid.sv
rtl/crc16_frame_receiver.sv
sim/tb_top.sv
